/* hw/rtl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/mrrc_pkg.sv */
// shared constants and types for the read range coalescer
`default_nettype none

package mrrc_pkg;

   localparam int ADDR_W     = 16;
   localparam int COUNT_W    = 8;
   localparam int STATION_W  = 8;
   localparam int AREA_W     = 2;
   localparam int GAP_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_MAX_GAP = 2'd0;
   localparam csr_idx_type CSR_STATION = 2'd1;
   localparam csr_idx_type CSR_AREA    = 2'd2;

   localparam logic [GAP_W-1:0]     MAX_GAP_RST = 7'd2;
   localparam logic [STATION_W-1:0] STATION_RST = 8'd1;
   localparam logic [AREA_W-1:0]    AREA_RST    = 2'd0;

   localparam int RESULT_LIMIT = 64;
   localparam int RES_CNT_W    = 7;

   localparam int REQ_TDATA_W = 16;
   localparam int START_LSB   = 0;
   localparam int COUNT_LSB   = 16;
   localparam int STATION_LSB = 24;
   localparam int AREA_LSB    = 32;
   localparam int RSP_TDATA_W = 40;

endpackage

`default_nettype wire

/* hw/rtl/mrrc_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module mrrc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/modbus_read_range_coalescer.sv */
// top level of the modbus read range coalescer
`default_nettype none

// Takes the variables of one station and area one beat at a time and, on the beat
// marked tlast, turns them into merged read requests. After the last beat the block is
// busy: a span check, then marking reads each variable from the variable ram and writes
// its cell (and the next for a two-register variable) in the cell bitmap ram, then the
// scan goes over span + max_gap + 1 cells, each with a read state and an evaluate state
// since the bitmap ram read is registered, and a closing state follows; a full result
// register makes it wait. An overflow group skips marking and scanning. After reset a
// clearing pass over all SPAN_CELLS cells zeroes the bitmap before the first beat is
// taken.
module modbus_read_range_coalescer #(
   parameter int MAX_VARS   = 64,
   parameter int SPAN_CELLS = 128
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [mrrc_pkg::REQ_TDATA_W-1:0]      req_tdata,  // var_address
   input  wire logic [0:0]                            req_tuser,  // is_double
   input  wire logic                                  req_tlast,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [mrrc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // rsp_tdata: start_address, cell_count, station, area, zero fill
   output logic      [0:0]                            rsp_tuser,  // overflow
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_we,
   input  wire logic [mrrc_pkg::CSR_IDX_W-1:0]        csr_addr,
   input  wire logic [mrrc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int VAW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int VCW = $clog2(MAX_VARS + 1);
   localparam int CW  = $clog2(SPAN_CELLS);
   localparam int SW  = $clog2(SPAN_CELLS + 1);
   localparam int JW  = $clog2(SPAN_CELLS + (1 << mrrc_pkg::GAP_W));
   localparam int AW  = mrrc_pkg::ADDR_W;
   localparam int NW  = mrrc_pkg::COUNT_W;
   localparam int SPW = AW + 2;
   localparam int RW  = mrrc_pkg::RES_CNT_W;

   localparam logic [CW-1:0]  CELL_LAST = CW'(SPAN_CELLS - 1);
   localparam logic [VCW-1:0] VAR_CAP   = VCW'(MAX_VARS);
   localparam logic [SPW-1:0] SPAN_CAP  = SPW'(SPAN_CELLS);
   localparam logic [RW-1:0]  RES_CAP   = RW'(mrrc_pkg::RESULT_LIMIT);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_CHECK  = 4'd2;
   localparam logic [3:0] ST_MK_RD  = 4'd3;
   localparam logic [3:0] ST_MK_W0  = 4'd4;
   localparam logic [3:0] ST_MK_W1  = 4'd5;
   localparam logic [3:0] ST_SC_RD  = 4'd6;
   localparam logic [3:0] ST_SC_EV  = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   // control registers
   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  clr_idx_ff, clr_idx_in;
   logic [VCW-1:0] var_count_ff, var_count_in;
   logic           too_many_ff, too_many_in;
   logic           in_req_ff, in_req_in;
   logic           pend_valid_ff, pend_valid_in;
   logic [RW-1:0]  res_n_ff, res_n_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [mrrc_pkg::GAP_W-1:0]     max_gap_ff, max_gap_in;
   logic [mrrc_pkg::STATION_W-1:0] station_ff, station_in;
   logic [mrrc_pkg::AREA_W-1:0]    area_ff, area_in;

   // group and scan payload registers
   logic [AW-1:0]  low_ff, low_in;
   logic [AW:0]    high_ff, high_in;
   logic [SW-1:0]  span_ff, span_in;
   logic [JW-1:0]  lim_ff, lim_in;
   logic [VAW-1:0] mk_idx_ff, mk_idx_in;
   logic [CW-1:0]  cell_ff, cell_in;
   logic [JW-1:0]  j_ff, j_in;
   logic [AW-1:0]  run_start_ff, run_start_in;
   logic [NW-1:0]  run_len_ff, run_len_in;
   logic [NW-1:0]  hole_ff, hole_in;
   logic [AW-1:0]  pend_start_ff, pend_start_in;
   logic [NW-1:0]  pend_count_ff, pend_count_in;
   logic [AW-1:0]  rsp_start_ff, rsp_start_in;
   logic [NW-1:0]  rsp_count_ff, rsp_count_in;
   logic [mrrc_pkg::STATION_W-1:0] rsp_station_ff, rsp_station_in;
   logic [mrrc_pkg::AREA_W-1:0]    rsp_area_ff, rsp_area_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   // ram ports
   logic           vwr_en, vrd_en;
   logic [VAW-1:0] vwr_addr, vrd_addr;
   logic [AW:0]    vwr_data, vrd_data;
   logic           uwr_en, urd_en;
   logic [CW-1:0]  uwr_addr, urd_addr;
   logic [0:0]     uwr_data, urd_data;

   // datapath
   logic           req_fire, out_free;
   logic [AW-1:0]  ld_addr;
   logic [AW:0]    ld_top;
   logic           ld_first;
   logic [SPW-1:0] span_full;
   logic           span_bad;
   logic [AW-1:0]  mk_diff;
   logic [CW-1:0]  mk_cell;
   logic [VCW-1:0] mk_next;
   logic           mk_done;
   logic           sc_in_span, sc_used;
   logic           sc_in_req_n, sc_close, sc_keep, sc_stall;
   logic [AW-1:0]  sc_start_n;
   logic [NW-1:0]  sc_run_n, sc_hole_n, sc_count;
   logic           push, push_last, push_ovf;
   logic [AW-1:0]  push_start;
   logic [NW-1:0]  push_count;

   mrrc_ram #(
      .WIDTH (AW + 1),
      .DEPTH (MAX_VARS)
   ) u_var_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vwr_addr),
      .wr_data (vwr_data),
      .rd_en   (vrd_en),
      .rd_addr (vrd_addr),
      .rd_data (vrd_data)
   );

   mrrc_ram #(
      .WIDTH (1),
      .DEPTH (SPAN_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (uwr_en),
      .wr_addr (uwr_addr),
      .wr_data (uwr_data),
      .rd_en   (urd_en),
      .rd_addr (urd_addr),
      .rd_data (urd_data)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ld_addr   = req_tdata;
   assign ld_top    = {1'b0, ld_addr} + (AW + 1)'(req_tuser[0]);
   assign ld_first  = (var_count_ff == '0) && !too_many_ff;
   assign span_full = {1'b0, high_ff} - {2'b00, low_ff} + SPW'(1);
   assign span_bad  = too_many_ff || (span_full > SPAN_CAP);
   assign mk_diff   = vrd_data[AW-1:0] - low_ff;
   assign mk_cell   = mk_diff[CW-1:0];
   assign mk_next   = VCW'(mk_idx_ff) + VCW'(1);
   assign mk_done   = (mk_next == var_count_ff);

   assign sc_in_span = j_ff < JW'(span_ff);
   assign sc_used    = sc_in_span && urd_data[0];

   // one scan step over the current cell
   always_comb begin
      sc_in_req_n = in_req_ff;
      sc_start_n  = run_start_ff;
      sc_run_n    = run_len_ff;
      sc_hole_n   = hole_ff;
      sc_close    = 1'b0;
      sc_count    = '0;
      if (in_req_ff) begin
         sc_run_n = run_len_ff + NW'(1);
         if (sc_used) begin
            sc_hole_n = '0;
         end else begin
            sc_hole_n = hole_ff + NW'(1);
         end
         if (sc_hole_n > NW'(max_gap_ff)) begin
            sc_close    = 1'b1;
            sc_count    = sc_run_n - sc_hole_n;
            sc_in_req_n = 1'b0;
            sc_hole_n   = '0;
         end
      end else if (sc_used) begin
         sc_in_req_n = 1'b1;
         sc_start_n  = low_ff + AW'(j_ff);
         sc_run_n    = NW'(1);
         sc_hole_n   = '0;
      end
   end

   assign sc_keep  = sc_close && (res_n_ff < RES_CAP);
   assign sc_stall = sc_keep && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      var_count_in  = var_count_ff;
      too_many_in   = too_many_ff;
      in_req_in     = in_req_ff;
      pend_valid_in = pend_valid_ff;
      res_n_in      = res_n_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      span_in       = span_ff;
      lim_in        = lim_ff;
      mk_idx_in     = mk_idx_ff;
      cell_in       = cell_ff;
      j_in          = j_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      hole_in       = hole_ff;
      pend_start_in = pend_start_ff;
      pend_count_in = pend_count_ff;
      vwr_en        = 1'b0;
      vwr_addr      = var_count_ff[VAW-1:0];
      vwr_data      = {req_tuser[0], ld_addr};
      vrd_en        = 1'b0;
      vrd_addr      = mk_idx_ff;
      uwr_en        = 1'b0;
      uwr_addr      = clr_idx_ff;
      uwr_data      = 1'b0;
      urd_en        = 1'b0;
      urd_addr      = j_ff[CW-1:0];
      push          = 1'b0;
      push_start    = pend_start_ff;
      push_count    = pend_count_ff;
      push_last     = 1'b0;
      push_ovf      = 1'b0;

      unique case (state_ff) inside
         ST_CLEAR: begin
            uwr_en = 1'b1;
            if (clr_idx_ff == CELL_LAST) begin
               state_in = ST_LOAD;
            end else begin
               clr_idx_in = clr_idx_ff + CW'(1);
            end
         end
         ST_LOAD: begin
            if (req_fire) begin
               if (ld_first) begin
                  low_in  = ld_addr;
                  high_in = ld_top;
               end else begin
                  if (ld_addr < low_ff) low_in = ld_addr;
                  if (ld_top > high_ff) high_in = ld_top;
               end
               if (var_count_ff < VAR_CAP) begin
                  vwr_en       = 1'b1;
                  var_count_in = var_count_ff + VCW'(1);
               end else begin
                  too_many_in = 1'b1;
               end
               if (req_tlast) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (span_bad) begin
               if (out_free) begin
                  push         = 1'b1;
                  push_start   = low_ff;
                  push_count   = '0;
                  push_last    = 1'b1;
                  push_ovf     = 1'b1;
                  var_count_in = '0;
                  too_many_in  = 1'b0;
                  low_in       = '0;
                  high_in      = '0;
                  state_in     = ST_LOAD;
               end
            end else begin
               span_in   = span_full[SW-1:0];
               lim_in    = JW'(span_full[SW-1:0]) + JW'(max_gap_ff);
               mk_idx_in = '0;
               state_in  = ST_MK_RD;
            end
         end
         ST_MK_RD: begin
            vrd_en   = 1'b1;
            state_in = ST_MK_W0;
         end
         ST_MK_W0, ST_MK_W1: begin
            uwr_en   = 1'b1;
            uwr_data = 1'b1;
            if (state_ff == ST_MK_W0) begin
               uwr_addr = mk_cell;
               cell_in  = mk_cell;
            end else begin
               uwr_addr = cell_ff + CW'(1);
            end
            if (state_ff == ST_MK_W0 && vrd_data[AW]) begin
               state_in = ST_MK_W1;
            end else if (mk_done) begin
               j_in          = '0;
               in_req_in     = 1'b0;
               run_start_in  = '0;
               run_len_in    = '0;
               hole_in       = '0;
               pend_valid_in = 1'b0;
               res_n_in      = '0;
               state_in      = ST_SC_RD;
            end else begin
               mk_idx_in = mk_next[VAW-1:0];
               state_in  = ST_MK_RD;
            end
         end
         ST_SC_RD: begin
            urd_en   = sc_in_span;
            state_in = ST_SC_EV;
         end
         ST_SC_EV: begin
            if (!sc_stall) begin
               in_req_in    = sc_in_req_n;
               run_start_in = sc_start_n;
               run_len_in   = sc_run_n;
               hole_in      = sc_hole_n;
               if (sc_keep) begin
                  push          = pend_valid_ff;
                  pend_start_in = run_start_ff;
                  pend_count_in = sc_count;
                  pend_valid_in = 1'b1;
                  res_n_in      = res_n_ff + RW'(1);
               end
               uwr_en   = sc_in_span;
               uwr_addr = j_ff[CW-1:0];
               if (j_ff == lim_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  j_in     = j_ff + JW'(1);
                  state_in = ST_SC_RD;
               end
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               in_req_in     = 1'b0;
               var_count_in  = '0;
               too_many_in   = 1'b0;
               low_in        = '0;
               high_in       = '0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_station_in = rsp_station_ff;
      rsp_area_in    = rsp_area_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_start_in   = push_start;
         rsp_count_in   = push_count;
         rsp_station_in = station_ff;
         rsp_area_in    = area_ff;
         rsp_last_in    = push_last;
         rsp_ovf_in     = push_ovf;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes
   always_comb begin
      max_gap_in = max_gap_ff;
      station_in = station_ff;
      area_in    = area_ff;
      if (csr_we) begin
         case (csr_addr)
            mrrc_pkg::CSR_MAX_GAP: max_gap_in = csr_wdata[mrrc_pkg::GAP_W-1:0];
            mrrc_pkg::CSR_STATION: station_in = csr_wdata[mrrc_pkg::STATION_W-1:0];
            mrrc_pkg::CSR_AREA:    area_in    = csr_wdata[mrrc_pkg::AREA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         var_count_ff  <= '0;
         too_many_ff   <= 1'b0;
         in_req_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         res_n_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         low_ff        <= '0;
         high_ff       <= '0;
         max_gap_ff    <= mrrc_pkg::MAX_GAP_RST;
         station_ff    <= mrrc_pkg::STATION_RST;
         area_ff       <= mrrc_pkg::AREA_RST;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         var_count_ff  <= var_count_in;
         too_many_ff   <= too_many_in;
         in_req_ff     <= in_req_in;
         pend_valid_ff <= pend_valid_in;
         res_n_ff      <= res_n_in;
         rsp_valid_ff  <= rsp_valid_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         max_gap_ff    <= max_gap_in;
         station_ff    <= station_in;
         area_ff       <= area_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff        <= span_in;
      lim_ff         <= lim_in;
      mk_idx_ff      <= mk_idx_in;
      cell_ff        <= cell_in;
      j_ff           <= j_in;
      run_start_ff   <= run_start_in;
      run_len_ff     <= run_len_in;
      hole_ff        <= hole_in;
      pend_start_ff  <= pend_start_in;
      pend_count_ff  <= pend_count_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_station_ff <= rsp_station_in;
      rsp_area_ff    <= rsp_area_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mrrc_pkg::RSP_TDATA_W'({rsp_area_ff, rsp_station_ff,
                                               rsp_count_ff, rsp_start_ff});
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/mrrc_checker.sv */
// port-level checks for the read range coalescer, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module mrrc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              req_tlast,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [mrrc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [0:0]                        rsp_tuser,
   input wire logic                              rsp_tlast
);

   logic [mrrc_pkg::COUNT_W-1:0]     rsp_count;
   logic [mrrc_pkg::RSP_TDATA_W+1:0] rsp_beat;

   assign rsp_count = rsp_tdata[mrrc_pkg::COUNT_LSB +: mrrc_pkg::COUNT_W];
   assign rsp_beat  = {rsp_tlast, rsp_tuser, rsp_tdata};

   // stalled result beat holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_beat))

   // error result closes the group
   `CHK_IMPL(a_ovf_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)

   // error result carries no cells
   `CHK_IMPL(a_ovf_count, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_count == '0)

   // group end makes the block busy
   `CHK_NEXT(a_last_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

endmodule

bind modbus_read_range_coalescer mrrc_checker u_mrrc_checker (.*);

`default_nettype wire
